// ===== hdl/stab_pkg.sv =====
// ----------------------------------------------------------------------------
// stab_pkg: shared types and constants of the slot table
// Mode and result-kind codes, register indexes, fixed field widths and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package stab_pkg;

  localparam int unsigned PRI_W      = 6;  // slot priority
  localparam int unsigned SPD_W      = 8;  // slot speed
  localparam int unsigned SEL_W      = 5;  // slot_select field
  localparam int unsigned SLOT_NUM_W = 5;  // slot_number field
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [PRI_W-1:0] CAP_RESET   = 6'd40;
  localparam logic [PRI_W-1:0] START_RESET = 6'd20;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_CAP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PRIORITY = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_UPDATE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_SLOT      = 2'd0,
    KIND_PURGE     = 2'd1,
    KIND_IDLE_TICK = 2'd2,
    KIND_UPDATE    = 2'd3
  } kind_e;

endpackage

`default_nettype wire

// ===== hdl/stab_if.sv =====
// ----------------------------------------------------------------------------
// stab_if: valid/ready channels of the slot table
// Command channel (stab_in_if) and result channel (stab_out_if).
// ----------------------------------------------------------------------------
`default_nettype none

interface stab_in_if #(
  parameter int unsigned ADDRESS_BITS = 14
);
  logic                            valid;
  logic                            ready;
  stab_pkg::mode_e                 mode;
  logic [ADDRESS_BITS-1:0]         address;
  logic [stab_pkg::SEL_W-1:0]      slot_select;
  logic [stab_pkg::SPD_W-1:0]      speed_value;
  logic                            in_use_value;

  modport source (output valid, mode, address, slot_select, speed_value, in_use_value,
                  input ready);
  modport sink   (input valid, mode, address, slot_select, speed_value, in_use_value,
                  output ready);
endinterface

interface stab_out_if;
  logic                            valid;
  logic                            ready;
  stab_pkg::kind_e                 kind;
  logic [stab_pkg::SLOT_NUM_W-1:0] slot_number;
  logic                            found;
  logic                            commissioned;
  logic                            last;

  modport source (output valid, kind, slot_number, found, commissioned, last,
                  input ready);
  modport sink   (input valid, kind, slot_number, found, commissioned, last,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/slot_table_with_aging_top.sv =====
// ----------------------------------------------------------------------------
// slot_table_with_aging_top: slot table with lookup, commissioning and aging
// Entries live in one RAM; a small sequencer sweeps them one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//  - in_i carries command beats (mode, address, slot_select, speed_value,
//    in_use_value); out_o carries result beats (kind, slot_number,
//    found, commissioned, last). A beat moves when valid and ready are high.
//  - cfg_we_i/cfg_idx_i/cfg_data_i write priority_cap (0) and
//    start_priority (1); write them only while no command is in flight.
//  - Lookup, query and tick sweep all SLOT_COUNT entries through the single
//    RAM read port, one entry per cycle unless a purge beat stalls a tick.
//    The result leaves through the output register in the final cycle.
//  - Update reads one entry at accept and rewrites it in state S_UPD once
//    the output register is free, then returns to idle.
//  - A tick gives up to SLOT_COUNT purge beats; last marks the final one.
//  - Ready is high only between commands; a new command is taken while the
//    previous result still sits in the output register.
//  - A stalled receiver freezes the sweep whenever a beat has to leave and
//    the output register is still full; nothing is dropped.
//  - Reset clears the per-slot valid bits, so every slot reads as all zero
//    right away; there is no clearing pass. Registers return to 40 and 20.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_table_with_aging_top #(
  parameter int unsigned SLOT_COUNT   = 32,
  parameter int unsigned ADDRESS_BITS = 14
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  stab_in_if.sink                                  in_i,
  stab_out_if.source                               out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [stab_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [stab_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W   = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int unsigned PRI_W   = stab_pkg::PRI_W;
  localparam int unsigned SPD_W   = stab_pkg::SPD_W;
  // entry layout: {address, priority, in_use, recent, speed}
  localparam int unsigned REC_BIT = SPD_W;
  localparam int unsigned USE_BIT = SPD_W + 1;
  localparam int unsigned PRI_LSB = SPD_W + 2;
  localparam int unsigned ADR_LSB = PRI_LSB + PRI_W;
  localparam int unsigned ENT_W   = ADR_LSB + ADDRESS_BITS;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_UPD    = 4'b1000
  } state_e;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                  state_q, state_d;
  logic [PRI_W-1:0]        cap_q, start_q;
  logic [SLOT_COUNT-1:0]   valid_q, valid_d;

  // command latched at accept
  stab_pkg::mode_e         mode_q;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [stab_pkg::SEL_W-1:0] sel_q;
  logic [SPD_W-1:0]        spd_q;
  logic                    use_q;

  // sweep pipeline: read issue counter and the entry under evaluation
  logic [CNT_W-1:0]        rd_idx_q, rd_idx_d;
  logic                    ev_v_q, ev_v_d;
  logic [IDX_W-1:0]        ev_idx_q, ev_idx_d;

  // lookup bookkeeping
  logic                    hit_q, hit_d;
  logic [IDX_W-1:0]        hit_idx_q, hit_idx_d;
  logic [PRI_W-1:0]        lowest_q, lowest_d;
  logic [IDX_W-1:0]        chosen_q, chosen_d;
  logic                    chosen_rec_q, chosen_rec_d;

  // tick: one purge held back so the final one can carry last
  logic                    pend_v_q, pend_v_d;
  logic [IDX_W-1:0]        pend_slot_q, pend_slot_d;

  // output register
  logic                    out_valid_q;
  stab_pkg::kind_e         out_kind_q, out_kind_d;
  logic [stab_pkg::SLOT_NUM_W-1:0] out_slot_q, out_slot_d;
  logic                    out_found_q, out_found_d;
  logic                    out_com_q, out_com_d;
  logic                    out_last_q, out_last_d;
  logic                    out_load;

  // --------------------------------------------------------------------------
  // RAM
  // --------------------------------------------------------------------------
  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  logic [ENT_W-1:0]        ram_wdata, ram_rdata;

  stab_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Handshakes and command decode
  // --------------------------------------------------------------------------
  logic in_acc;
  logic out_free;
  logic [6:0] in_sel_w, sel_w;
  logic in_sel_ok, sel_ok;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign in_sel_w  = 7'(in_i.slot_select);
  assign in_sel_ok = in_sel_w < 7'(SLOT_COUNT);
  assign sel_w     = 7'(sel_q);
  assign sel_ok    = sel_w < 7'(SLOT_COUNT);

  // --------------------------------------------------------------------------
  // Entry under evaluation; a never-written slot reads as all zero
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]        cur_idx;
  logic [ENT_W-1:0]        ent;
  logic [ADDRESS_BITS-1:0] e_addr;
  logic [PRI_W-1:0]        e_pri;
  logic                    e_use, e_rec;
  logic [SPD_W-1:0]        e_spd;

  assign cur_idx = (state_q == S_UPD) ? sel_w[IDX_W-1:0] : ev_idx_q;
  assign ent     = valid_q[cur_idx] ? ram_rdata : '0;
  assign e_addr  = ent[ENT_W-1:ADR_LSB];
  assign e_pri   = ent[ADR_LSB-1:PRI_LSB];
  assign e_use   = ent[USE_BIT];
  assign e_rec   = ent[REC_BIT];
  assign e_spd   = ent[SPD_W-1:0];

  // tick aging of one entry
  logic [PRI_W-1:0]  t_pri;
  logic              t_purge;
  logic [ENT_W-1:0]  t_ent;

  always_comb begin
    t_pri   = e_pri;
    t_purge = 1'b0;
    t_ent   = {e_addr, e_pri, e_use, 1'b0, e_spd};
    if (e_rec) begin
      if (e_pri < cap_q) begin
        t_pri = e_pri + 1'b1;
      end
      t_ent = {e_addr, t_pri, e_use, 1'b0, e_spd};
    end else if (e_spd == '0 && !e_use) begin
      if (e_pri != '0) begin
        t_pri = e_pri - 1'b1;
      end
      t_purge = (t_pri == '0);
      // idle slot already has speed zero and in_use clear
      t_ent   = {(t_purge ? {ADDRESS_BITS{1'b0}} : e_addr), t_pri, 1'b0, 1'b0, e_spd};
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic is_scan_lookup;
  logic stall;
  logic rd_done;
  logic [6:0] pend_w, hit_w, chosen_w;

  assign is_scan_lookup = (mode_q == stab_pkg::MODE_LOOKUP) ||
                          (mode_q == stab_pkg::MODE_QUERY);
  assign stall   = ev_v_q && !is_scan_lookup && t_purge && pend_v_q && !out_free;
  assign rd_done = (rd_idx_q == CNT_W'(SLOT_COUNT));
  assign pend_w   = 7'(pend_slot_q);
  assign hit_w    = 7'(hit_idx_q);
  assign chosen_w = 7'(chosen_q);

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    rd_idx_d     = rd_idx_q;
    ev_v_d       = ev_v_q;
    ev_idx_d     = ev_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    lowest_d     = lowest_q;
    chosen_d     = chosen_q;
    chosen_rec_d = chosen_rec_q;
    pend_v_d     = pend_v_q;
    pend_slot_d  = pend_slot_q;
    ram_we       = 1'b0;
    ram_waddr    = ev_idx_q;
    ram_wdata    = t_ent;
    ram_re       = 1'b0;
    ram_raddr    = rd_idx_q[IDX_W-1:0];
    out_load     = 1'b0;
    out_kind_d   = stab_pkg::KIND_SLOT;
    out_slot_d   = '0;
    out_found_d  = 1'b0;
    out_com_d    = 1'b0;
    out_last_d   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rd_idx_d = '0;
          ev_v_d   = 1'b0;
          hit_d    = 1'b0;
          lowest_d = cap_q;
          chosen_d = '0;
          pend_v_d = 1'b0;
          if (in_i.mode == stab_pkg::MODE_UPDATE) begin
            ram_re    = in_sel_ok;
            ram_raddr = in_sel_w[IDX_W-1:0];
            state_d   = S_UPD;
          end else begin
            state_d   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (!stall) begin
          // issue the next read
          if (!rd_done) begin
            ram_re   = 1'b1;
            rd_idx_d = rd_idx_q + 1'b1;
          end
          ev_v_d   = !rd_done;
          ev_idx_d = rd_idx_q[IDX_W-1:0];

          // evaluate the entry held in the RAM read register
          if (ev_v_q) begin
            if (is_scan_lookup) begin
              if (ev_idx_q == '0) begin
                chosen_rec_d = e_rec;
              end else begin
                if (!hit_q && e_addr == addr_q) begin
                  hit_d     = 1'b1;
                  hit_idx_d = ev_idx_q;
                end
                if (e_pri < lowest_q) begin
                  lowest_d     = e_pri;
                  chosen_d     = ev_idx_q;
                  chosen_rec_d = e_rec;
                end
              end
            end else begin
              ram_we = 1'b1;
              if (t_purge) begin
                if (pend_v_q) begin
                  out_load   = 1'b1;
                  out_kind_d = stab_pkg::KIND_PURGE;
                  out_slot_d = pend_w[stab_pkg::SLOT_NUM_W-1:0];
                  out_last_d = 1'b0;
                end
                pend_v_d    = 1'b1;
                pend_slot_d = ev_idx_q;
              end
            end
          end

          if (rd_done && !ev_v_q) begin
            state_d = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (is_scan_lookup) begin
            out_kind_d  = stab_pkg::KIND_SLOT;
            out_found_d = hit_q;
            out_com_d   = !hit_q && (mode_q == stab_pkg::MODE_LOOKUP);
            out_slot_d  = hit_q ? hit_w[stab_pkg::SLOT_NUM_W-1:0]
                                : chosen_w[stab_pkg::SLOT_NUM_W-1:0];
            // commission: recent mark of the chosen slot is kept
            if (out_com_d) begin
              ram_we    = 1'b1;
              ram_waddr = chosen_q;
              ram_wdata = {addr_q, start_q, 1'b1, chosen_rec_q, {SPD_W{1'b0}}};
            end
          end else begin
            pend_v_d = 1'b0;
            if (pend_v_q) begin
              out_kind_d = stab_pkg::KIND_PURGE;
              out_slot_d = pend_w[stab_pkg::SLOT_NUM_W-1:0];
            end else begin
              out_kind_d = stab_pkg::KIND_IDLE_TICK;
            end
          end
        end
      end

      S_UPD: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = stab_pkg::KIND_UPDATE;
          out_slot_d = sel_q;
          state_d    = S_IDLE;
          if (sel_ok) begin
            ram_we    = 1'b1;
            ram_waddr = sel_w[IDX_W-1:0];
            ram_wdata = {e_addr, e_pri, use_q, 1'b1, spd_q};
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      rd_idx_q    <= '0;
      ev_v_q      <= 1'b0;
      hit_q       <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= stab_pkg::CAP_RESET;
      start_q     <= stab_pkg::START_RESET;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      rd_idx_q <= rd_idx_d;
      ev_v_q   <= ev_v_d;
      hit_q    <= hit_d;
      pend_v_q <= pend_v_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          stab_pkg::CFG_PRIORITY_CAP:   cap_q   <= cfg_data_i;
          stab_pkg::CFG_START_PRIORITY: start_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= in_i.mode;
      addr_q <= in_i.address;
      sel_q  <= in_i.slot_select;
      spd_q  <= in_i.speed_value;
      use_q  <= in_i.in_use_value;
    end
    ev_idx_q     <= ev_idx_d;
    hit_idx_q    <= hit_idx_d;
    lowest_q     <= lowest_d;
    chosen_q     <= chosen_d;
    chosen_rec_q <= chosen_rec_d;
    pend_slot_q  <= pend_slot_d;
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_slot_q  <= out_slot_d;
      out_found_q <= out_found_d;
      out_com_q   <= out_com_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.slot_number  = out_slot_q;
  assign out_o.found        = out_found_q;
  assign out_o.commissioned = out_com_q;
  assign out_o.last         = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/stab_ram.sv =====
// ----------------------------------------------------------------------------
// stab_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module stab_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the slot table with aging
// Sends lookup, query, minute-tick and update commands with random gaps and
// random result back-pressure. A mirror of the slot table predicts every
// result beat, and each beat is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import stab_pkg::*;

  localparam int unsigned SLOTS  = 32;
  localparam int unsigned ADDR_W = 14;

  typedef struct {
    mode_e               mode;
    logic [ADDR_W-1:0]   address;
    logic [SEL_W-1:0]    slot_select;
    logic [SPD_W-1:0]    speed_value;
    logic                in_use_value;
  } command_t;

  typedef struct {
    kind_e                 kind;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic                  found;
    logic                  commissioned;
    logic                  last;
  } answer_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  stab_in_if #(.ADDRESS_BITS(ADDR_W)) cmd_ch ();
  stab_out_if                         ans_ch ();

  slot_table_with_aging_top #(
    .SLOT_COUNT  (SLOTS),
    .ADDRESS_BITS(ADDR_W)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (cmd_ch),
    .out_o     (ans_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Mirror of the slot table and its two registers
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] tbl_addr   [SLOTS];
  logic [PRI_W-1:0]  tbl_pri    [SLOTS];
  logic              tbl_in_use [SLOTS];
  logic              tbl_recent [SLOTS];
  logic [SPD_W-1:0]  tbl_speed  [SLOTS];
  logic [PRI_W-1:0]  cap_reg;
  logic [PRI_W-1:0]  start_reg;

  command_t command_q [$];   // commands waiting for the driver
  answer_t  answer_q  [$];   // result beats the table owes us, oldest first

  command_t cur_cmd;         // command currently on the bus
  int       send_gap;
  int       recv_stall;
  bit       drain_hold;      // sender waits until every owed beat is back
  bit       calm;            // no idling on either side
  int       fail_count;

  // small address pool so lookups hit often; zero and all-ones included
  logic [ADDR_W-1:0] addr_pool [8] = '{14'h0000, 14'h3FFF, 14'h0001, 14'h2000,
                                       14'h1555, 14'h2AAA, 14'h0100, 14'h3E00};

  // Address search skips slot 0, exactly as the block does.
  function automatic int find_slot(logic [ADDR_W-1:0] addr);
    for (int i = 1; i < SLOTS; i++)
      if (tbl_addr[i] == addr) return i;
    return -1;
  endfunction

  // Running minimum from the cap down; stops at the first zero-priority slot.
  // Nothing below the cap means slot 0.
  function automatic int pick_victim();
    logic [PRI_W-1:0] lowest;
    int               chosen;
    lowest = cap_reg;
    chosen = 0;
    for (int i = 1; i < SLOTS; i++) begin
      if (tbl_pri[i] < lowest) begin
        lowest = tbl_pri[i];
        chosen = i;
      end
      if (lowest == 0) break;
    end
    return chosen;
  endfunction

  function automatic void owe_answer(kind_e k, int slot, logic f, logic c, logic l);
    answer_t a;
    a.kind         = k;
    a.slot_number  = slot[SLOT_NUM_W-1:0];
    a.found        = f;
    a.commissioned = c;
    a.last         = l;
    answer_q.push_back(a);
  endfunction

  // Apply one accepted command to the mirror and queue the beats it causes.
  function automatic void step_table(command_t c);
    int s;
    int purged [$];
    case (c.mode)
      MODE_LOOKUP, MODE_QUERY: begin
        s = find_slot(c.address);
        if (s >= 0) begin
          owe_answer(KIND_SLOT, s, 1'b1, 1'b0, 1'b1);
        end else begin
          s = pick_victim();
          if (c.mode == MODE_LOOKUP) begin
            // recent mark is left untouched on commissioning
            tbl_addr[s]   = c.address;
            tbl_pri[s]    = start_reg;
            tbl_in_use[s] = 1'b1;
            tbl_speed[s]  = '0;
          end
          owe_answer(KIND_SLOT, s, 1'b0, c.mode == MODE_LOOKUP, 1'b1);
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_recent[i]) begin
            tbl_recent[i] = 1'b0;
            if (tbl_pri[i] < cap_reg) tbl_pri[i] = tbl_pri[i] + 1'b1;
          end else if (tbl_speed[i] == 0 && !tbl_in_use[i]) begin
            if (tbl_pri[i] > 0) tbl_pri[i] = tbl_pri[i] - 1'b1;
            // a slot already at zero is purged again on every tick
            if (tbl_pri[i] == 0) begin
              tbl_addr[i]   = '0;
              tbl_speed[i]  = '0;
              tbl_in_use[i] = 1'b0;
              purged.push_back(i);
            end
          end
        end
        if (purged.size() == 0)
          owe_answer(KIND_IDLE_TICK, 0, 1'b0, 1'b0, 1'b1);
        else
          foreach (purged[j])
            owe_answer(KIND_PURGE, purged[j], 1'b0, 1'b0, j == purged.size() - 1);
      end
      default: begin
        tbl_speed[c.slot_select]  = c.speed_value;
        tbl_in_use[c.slot_select] = c.in_use_value;
        tbl_recent[c.slot_select] = 1'b1;
        owe_answer(KIND_UPDATE, c.slot_select, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic command_t rand_command();
    command_t c;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 40)      c.mode = MODE_LOOKUP;
    else if (r < 55) c.mode = MODE_QUERY;
    else if (r < 70) c.mode = MODE_TICK;
    else             c.mode = MODE_UPDATE;
    // unused fields carry noise too
    if ($urandom_range(0, 99) < 70) c.address = addr_pool[$urandom_range(0, 7)];
    else                            c.address = ADDR_W'($urandom);
    c.slot_select  = SEL_W'($urandom_range(0, SLOTS - 1));
    c.speed_value  = $urandom_range(0, 1) ? SPD_W'($urandom) : '0;
    c.in_use_value = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic void push_cmd(mode_e m, logic [ADDR_W-1:0] a, logic [SEL_W-1:0] sel,
                                   logic [SPD_W-1:0] spd, logic busy);
    command_t c;
    c.mode         = m;
    c.address      = a;
    c.slot_select  = sel;
    c.speed_value  = spd;
    c.in_use_value = busy;
    command_q.push_back(c);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Command driver: one beat held until the table takes it, then a random
  // gap (or a full drain when drain_hold is set) before the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    logic     next_valid;
    command_t next_cmd;
    if (!rst_ni) begin
      cmd_ch.valid        <= 1'b0;
      cmd_ch.mode         <= MODE_LOOKUP;
      cmd_ch.address      <= '0;
      cmd_ch.slot_select  <= '0;
      cmd_ch.speed_value  <= '0;
      cmd_ch.in_use_value <= 1'b0;
      send_gap            = 0;
      drain_hold          = 1'b0;
    end else begin
      next_valid = cmd_ch.valid;
      next_cmd   = cur_cmd;
      if (cmd_ch.valid && cmd_ch.ready) begin
        step_table(cur_cmd);
        next_valid = 1'b0;
        send_gap   = pick_gap();
        if (!calm && $urandom_range(0, 99) < 3) drain_hold = 1'b1;
      end
      if (!next_valid) begin
        if (drain_hold) begin
          if (answer_q.size() == 0) drain_hold = 1'b0;
        end else if (send_gap > 0) begin
          send_gap--;
        end else if (command_q.size() > 0) begin
          next_cmd   = command_q.pop_front();
          next_valid = 1'b1;
        end
      end
      cur_cmd = next_cmd;
      cmd_ch.valid        <= next_valid;
      cmd_ch.mode         <= next_cmd.mode;
      cmd_ch.address      <= next_cmd.address;
      cmd_ch.slot_select  <= next_cmd.slot_select;
      cmd_ch.speed_value  <= next_cmd.speed_value;
      cmd_ch.in_use_value <= next_cmd.in_use_value;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: random stalls on ready, in-order compare of each beat
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : ans_monitor
    answer_t want;
    if (!rst_ni) begin
      ans_ch.ready <= 1'b0;
      recv_stall   = 0;
    end else begin
      if (ans_ch.valid && ans_ch.ready) begin
        if (answer_q.size() == 0) begin
          $error("result beat with nothing owed: kind %0d slot %0d",
                 ans_ch.kind, ans_ch.slot_number);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          check_field("kind",         want.kind,         ans_ch.kind);
          check_field("slot_number",  want.slot_number,  ans_ch.slot_number);
          check_field("found",        want.found,        ans_ch.found);
          check_field("commissioned", want.commissioned, ans_ch.commissioned);
          check_field("last",         want.last,         ans_ch.last);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        ans_ch.ready <= 1'b0;
      end else begin
        ans_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) recv_stall = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register writes; only called while the table is idle
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_PRIORITY_CAP) cap_reg   = val;
    else                         start_reg = val;
  endtask

  task automatic set_config(int cap, int start);
    write_reg(CFG_PRIORITY_CAP,   CFG_DATA_W'(cap));
    write_reg(CFG_START_PRIORITY, CFG_DATA_W'(start));
  endtask

  // Wait for the driver to empty and every owed beat to come back, then let
  // a full sweep's worth of cycles pass so the sequencer is surely idle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (command_q.size() != 0 || cmd_ch.valid || answer_q.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic run_random(int n);
    repeat (n) command_q.push_back(rand_command());
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus phases
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [ADDR_W-1:0] fresh;
    bit                taken [int];

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_PRIORITY_CAP;
    cfg_data_i          = '0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.mode         = MODE_LOOKUP;
    cmd_ch.address      = '0;
    cmd_ch.slot_select  = '0;
    cmd_ch.speed_value  = '0;
    cmd_ch.in_use_value = 1'b0;
    ans_ch.ready        = 1'b0;
    calm                = 1'b0;
    fail_count          = 0;
    cap_reg             = CAP_RESET;
    start_reg           = START_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_addr[i]   = '0;
      tbl_pri[i]    = '0;
      tbl_in_use[i] = 1'b0;
      tbl_recent[i] = 1'b0;
      tbl_speed[i]  = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset values (cap 40, start 20)
    push_cmd(MODE_LOOKUP, 14'h3FFF, 5'd0,  8'h00, 1'b0); // miss, commission slot 1
    push_cmd(MODE_LOOKUP, 14'h3FFF, 5'd31, 8'hFF, 1'b1); // hit
    push_cmd(MODE_QUERY,  14'h0001, 5'd0,  8'h00, 1'b0); // miss, nothing written
    push_cmd(MODE_LOOKUP, 14'h0000, 5'd0,  8'h00, 1'b0); // zero hits a free slot
    push_cmd(MODE_LOOKUP, 14'h1555, 5'd0,  8'h00, 1'b0);
    push_cmd(MODE_QUERY,  14'h1555, 5'd0,  8'h00, 1'b0);
    push_cmd(MODE_UPDATE, 14'h0000, 5'd1,  8'hFF, 1'b1);
    push_cmd(MODE_UPDATE, 14'h3FFF, 5'd31, 8'h00, 1'b0);
    push_cmd(MODE_UPDATE, 14'h0000, 5'd0,  8'hAA, 1'b1); // slot 0 busy
    push_cmd(MODE_TICK,   14'h2AAA, 5'd17, 8'h55, 1'b1); // raises and mass purge
    push_cmd(MODE_TICK,   14'h0000, 5'd0,  8'h00, 1'b0); // idle zero slots purge again
    push_cmd(MODE_UPDATE, 14'h0000, 5'd2,  8'h00, 1'b0);
    push_cmd(MODE_UPDATE, 14'h0000, 5'd0,  8'h00, 1'b0);
    push_cmd(MODE_TICK,   14'h0000, 5'd0,  8'h00, 1'b0);
    push_cmd(MODE_LOOKUP, 14'h2AAA, 5'd0,  8'h00, 1'b0);
    push_cmd(MODE_QUERY,  14'h3FFF, 5'd0,  8'h00, 1'b0);
    push_cmd(MODE_UPDATE, 14'h0000, 5'd1,  8'h00, 1'b0);
    push_cmd(MODE_TICK,   14'h0000, 5'd0,  8'h00, 1'b0);
    wait_drained();

    // Cap at 1, start above it: fill every slot, then the table is
    // full at the cap so slot 0 gets taken; raises leave priority 63 alone
    // and ticks find nothing to purge.
    set_config(1, 63);
    for (int k = 0; k < 33; k++) begin
      do fresh = ADDR_W'($urandom_range(1, (1 << ADDR_W) - 1));
      while (taken.exists(fresh));
      taken[fresh] = 1'b1;
      push_cmd(k == 32 ? MODE_QUERY : MODE_LOOKUP, fresh, SEL_W'($urandom),
               SPD_W'($urandom), 1'($urandom));
    end
    push_cmd(MODE_LOOKUP, fresh, 5'd0, 8'h00, 1'b0);      // all at cap: slot 0
    push_cmd(MODE_UPDATE, 14'h0000, 5'd5,  8'h09, 1'b1);
    push_cmd(MODE_UPDATE, 14'h0000, 5'd31, 8'h00, 1'b1);
    push_cmd(MODE_TICK,   14'h0000, 5'd0,  8'h00, 1'b0);
    push_cmd(MODE_UPDATE, 14'h0000, 5'd7,  8'h00, 1'b0);
    push_cmd(MODE_TICK,   14'h0000, 5'd0,  8'h00, 1'b0);
    push_cmd(MODE_TICK,   14'h0000, 5'd0,  8'h00, 1'b0);
    wait_drained();

    // Random phases across register settings
    set_config(63, 0);
    run_random(80);
    set_config(63, 63);
    run_random(80);

    // stretch with no idling on either side
    set_config(CAP_RESET, START_RESET);
    calm = 1'b1;
    run_random(80);
    calm = 1'b0;

    set_config($urandom_range(1, 63), $urandom_range(0, 63));
    run_random(80);

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    #30_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
